// ===== src/ir_remote_pulse_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// IR remote pulse encoder assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef IR_REMOTE_PULSE_ENCODER_ASSERT_SVH
`define IR_REMOTE_PULSE_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define IRPE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define IRPE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/irpe_pkg.sv =====
// ----------------------------------------------------------------------------
// IR remote pulse encoder package
// Protocol and frame phase codes, segment structs and the timing tables.
// ----------------------------------------------------------------------------
`default_nettype none

package irpe_pkg;

	localparam int DUR_W = 14;

	typedef enum logic [2:0] {
		PR_SONY    = 3'd0,
		PR_NEC     = 3'd1,
		PR_WHYNTER = 3'd2,
		PR_RC5     = 3'd3,
		PR_RC6     = 3'd4,
		PR_PANA    = 3'd5,
		PR_JVC     = 3'd6,
		PR_SAMSUNG = 3'd7
	} proto_t;

	typedef enum logic [3:0] {
		PH_IDLE        = 4'd0,
		PH_LEAD_MARK   = 4'd1,
		PH_LEAD_SPACE  = 4'd2,
		PH_HDR_MARK    = 4'd3,
		PH_HDR_SPACE   = 4'd4,
		PH_START_A     = 4'd5,
		PH_START_B     = 4'd6,
		PH_START_C     = 4'd7,
		PH_BIT_A       = 4'd8,
		PH_BIT_B       = 4'd9,
		PH_TRAIL_MARK  = 4'd10,
		PH_TRAIL_SPACE = 4'd11,
		PH_DONE        = 4'd12
	} phase_t;

	typedef logic [DUR_W-1:0] dur_t;

	// What the segment selector needs to know about the frame.
	typedef struct packed {
		proto_t proto;
		phase_t phase;
		logic   skip_hdr;
		logic   bits_zero;
		logic   cur_bit;
		logic   rc6_wide;
	} seg_in_t;

	// The segment that comes next, if the frame has one.
	typedef struct packed {
		logic   found;
		logic   level;
		dur_t   dur;
		phase_t next;
		logic   shift;
	} seg_out_t;

	function automatic logic [5:0] carrier_of(input proto_t p);
		unique case (p)
			PR_RC5, PR_RC6: carrier_of = 6'd36;
			PR_PANA:        carrier_of = 6'd35;
			default:        carrier_of = 6'd38;
		endcase
	endfunction

	function automatic dur_t hdr_mark_of(input proto_t p);
		unique case (p)
			PR_SONY:    hdr_mark_of = 14'd2400;
			PR_NEC:     hdr_mark_of = 14'd9000;
			PR_WHYNTER: hdr_mark_of = 14'd2850;
			PR_RC5:     hdr_mark_of = 14'd0;
			PR_RC6:     hdr_mark_of = 14'd2666;
			PR_PANA:    hdr_mark_of = 14'd3502;
			PR_JVC:     hdr_mark_of = 14'd8000;
			PR_SAMSUNG: hdr_mark_of = 14'd5000;
		endcase
	endfunction

	function automatic dur_t hdr_space_of(input proto_t p);
		unique case (p)
			PR_SONY:    hdr_space_of = 14'd600;
			PR_NEC:     hdr_space_of = 14'd4500;
			PR_WHYNTER: hdr_space_of = 14'd2850;
			PR_RC5:     hdr_space_of = 14'd0;
			PR_RC6:     hdr_space_of = 14'd889;
			PR_PANA:    hdr_space_of = 14'd1750;
			PR_JVC:     hdr_space_of = 14'd4000;
			PR_SAMSUNG: hdr_space_of = 14'd5000;
		endcase
	endfunction

	function automatic dur_t pd_mark_of(input proto_t p);
		unique case (p)
			PR_NEC, PR_SAMSUNG: pd_mark_of = 14'd560;
			PR_WHYNTER:         pd_mark_of = 14'd750;
			PR_PANA:            pd_mark_of = 14'd502;
			PR_JVC:             pd_mark_of = 14'd600;
			default:            pd_mark_of = 14'd0;
		endcase
	endfunction

	function automatic dur_t pd_one_of(input proto_t p);
		unique case (p)
			PR_NEC, PR_JVC, PR_SAMSUNG: pd_one_of = 14'd1600;
			PR_WHYNTER:                 pd_one_of = 14'd2150;
			PR_PANA:                    pd_one_of = 14'd1244;
			default:                    pd_one_of = 14'd0;
		endcase
	endfunction

	function automatic dur_t pd_zero_of(input proto_t p);
		unique case (p)
			PR_NEC, PR_SAMSUNG: pd_zero_of = 14'd560;
			PR_WHYNTER:         pd_zero_of = 14'd750;
			PR_PANA:            pd_zero_of = 14'd400;
			PR_JVC:             pd_zero_of = 14'd550;
			default:            pd_zero_of = 14'd0;
		endcase
	endfunction

endpackage

`default_nettype wire

// ===== src/irpe_seg.sv =====
// ----------------------------------------------------------------------------
// IR remote pulse encoder segment selector
// Picks the next mark or space segment of a frame from its phase.
// ----------------------------------------------------------------------------
`default_nettype none

module irpe_seg (
	input  wire irpe_pkg::seg_in_t seg_in,
	output irpe_pkg::seg_out_t     seg_out
);
	import irpe_pkg::*;

	phase_t ph;
	logic   is_sony;
	logic   is_rc5;
	logic   is_rc6;
	logic   is_why;
	logic   b;
	dur_t   rc6_t;

	assign is_sony = (seg_in.proto == PR_SONY);
	assign is_rc5  = (seg_in.proto == PR_RC5);
	assign is_rc6  = (seg_in.proto == PR_RC6);
	assign is_why  = (seg_in.proto == PR_WHYNTER);
	assign b       = seg_in.cur_bit;
	assign rc6_t   = seg_in.rc6_wide ? 14'd888 : 14'd444;

	always_comb begin
		// Phases that send nothing for this frame are passed over in order.
		ph = seg_in.phase;
		if (ph == PH_LEAD_MARK && !is_why) ph = PH_HDR_MARK;
		if (ph == PH_HDR_MARK && (is_rc5 || seg_in.skip_hdr)) ph = PH_START_A;
		if (ph == PH_START_A && !is_rc5 && !is_rc6) ph = PH_BIT_A;
		if (ph == PH_BIT_A && seg_in.bits_zero) ph = PH_TRAIL_MARK;
		if (ph == PH_TRAIL_MARK && (is_sony || is_rc5 || is_rc6)) ph = PH_DONE;
		if (ph == PH_TRAIL_SPACE && !is_why) ph = PH_DONE;

		seg_out = '{found: 1'b1, level: 1'b0, dur: '0, next: PH_DONE, shift: 1'b0};
		unique case (ph)
			PH_LEAD_MARK: begin
				seg_out.level = 1'b1;
				seg_out.dur   = 14'd750;
				seg_out.next  = PH_LEAD_SPACE;
			end
			PH_LEAD_SPACE: begin
				seg_out.dur  = 14'd750;
				seg_out.next = PH_HDR_MARK;
			end
			PH_HDR_MARK: begin
				seg_out.level = 1'b1;
				seg_out.dur   = hdr_mark_of(seg_in.proto);
				seg_out.next  = PH_HDR_SPACE;
			end
			PH_HDR_SPACE: begin
				seg_out.dur  = hdr_space_of(seg_in.proto);
				seg_out.next = PH_START_A;
			end
			PH_START_A: begin
				seg_out.level = 1'b1;
				seg_out.dur   = is_rc5 ? 14'd889 : 14'd444;
				seg_out.next  = PH_START_B;
			end
			PH_START_B: begin
				seg_out.dur  = is_rc5 ? 14'd889 : 14'd444;
				seg_out.next = is_rc5 ? PH_START_C : PH_BIT_A;
			end
			PH_START_C: begin
				seg_out.level = 1'b1;
				seg_out.dur   = 14'd889;
				seg_out.next  = PH_BIT_A;
			end
			PH_BIT_A: begin
				seg_out.next = PH_BIT_B;
				if (is_sony) begin
					seg_out.level = 1'b1;
					seg_out.dur   = b ? 14'd1200 : 14'd600;
				end else if (is_rc5) begin
					seg_out.level = !b;
					seg_out.dur   = 14'd889;
				end else if (is_rc6) begin
					seg_out.level = b;
					seg_out.dur   = rc6_t;
				end else begin
					seg_out.level = 1'b1;
					seg_out.dur   = pd_mark_of(seg_in.proto);
				end
			end
			PH_BIT_B: begin
				seg_out.next  = PH_BIT_A;
				seg_out.shift = 1'b1;
				if (is_sony) begin
					seg_out.dur = 14'd600;
				end else if (is_rc5) begin
					seg_out.level = b;
					seg_out.dur   = 14'd889;
				end else if (is_rc6) begin
					seg_out.level = !b;
					seg_out.dur   = rc6_t;
				end else begin
					seg_out.dur = b ? pd_one_of(seg_in.proto) : pd_zero_of(seg_in.proto);
				end
			end
			PH_TRAIL_MARK: begin
				seg_out.level = 1'b1;
				seg_out.dur   = pd_mark_of(seg_in.proto);
				seg_out.next  = PH_TRAIL_SPACE;
			end
			PH_TRAIL_SPACE: begin
				seg_out.dur  = 14'd750;
				seg_out.next = PH_DONE;
			end
			default: begin
				seg_out.found = 1'b0;
				seg_out.next  = PH_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/ir_remote_pulse_encoder.sv =====
// ----------------------------------------------------------------------------
// IR remote pulse encoder
// Builds the mark/space envelope of NEC, Whynter, Samsung, JVC, Sony, RC5,
// RC6 and Panasonic remote frames, one microsecond per tick request.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on req_valid/req_stall with the fields operation, protocol,
// payload, bit_count, address and repeat_req. A request with operation set
// starts a frame; it is taken only while no frame runs, otherwise it is
// answered with start_accepted low and the frame goes on untouched. A request
// with operation clear is a one-microsecond tick: its result reports whether
// that microsecond is a mark, and the segment timer counts down by one.
// Every request yields exactly one result on res_valid/res_stall carrying
// ir_mark, busy_res, start_accepted and carrier_khz.
// One request is taken in every cycle while req_stall is low, and its
// result is registered: the frame state and the segment selector form a
// single pass between the state registers and the result register.
// A two-entry output buffer decouples the sides, so a request is still taken
// while one result waits; req_stall rises only once both entries are full,
// and nothing is lost or repeated while the receiver stalls.
// Reset (arst_n low) empties the output buffer and returns the frame state
// to idle, with the output level at space.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_remote_pulse_encoder #(
	parameter int DATA_BITS  = 32,
	parameter int ADDR_BITS  = 16,
	parameter int TIMER_BITS = 14
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire logic                 operation,
	input  wire logic [2:0]           protocol,
	input  wire logic [DATA_BITS-1:0] payload,
	input  wire logic [5:0]           bit_count,
	input  wire logic [ADDR_BITS-1:0] address,
	input  wire logic                 repeat_req,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output logic                      ir_mark,
	output logic                      busy_res,
	output logic                      start_accepted,
	output logic [5:0]                carrier_khz
);
	import irpe_pkg::*;

	// Bit counter must hold the Panasonic total of address plus data bits.
	localparam int CNT_W = $clog2(ADDR_BITS + DATA_BITS + 1);
	localparam int SH_W  = $clog2(DATA_BITS);
	localparam logic [5:0]       DATA_BITS_6 = 6'(DATA_BITS);
	localparam logic [CNT_W-1:0] DATA_CNT    = CNT_W'(DATA_BITS);
	localparam logic [CNT_W-1:0] PANA_CNT    = CNT_W'(ADDR_BITS + DATA_BITS);
	localparam logic [CNT_W-1:0] RC6_WIDE_IX = CNT_W'(3);

	typedef struct packed {
		logic       mark;
		logic       busy;
		logic       acc;
		logic [5:0] khz;
	} result_t;

	// Frame state.
	logic                  active_q;
	proto_t                proto_q;
	logic [DATA_BITS-1:0]  data_q;
	logic [ADDR_BITS-1:0]  addr_q;
	logic [CNT_W-1:0]      bits_left_q;
	logic [CNT_W-1:0]      bit_total_q;
	phase_t                phase_q;
	logic [TIMER_BITS-1:0] timer_q;
	logic                  level_q;
	logic                  skip_q;

	// Output buffer: main entry drives the ports, skid entry catches overflow.
	result_t out_q;
	logic    out_v_q;
	result_t skid_q;
	logic    skid_v_q;

	logic                  accept;
	logic                  take;
	logic                  start_take;
	logic                  is_tick;
	logic [5:0]            n_sat;
	logic [SH_W-1:0]       sh_amt;
	logic                  run;
	logic [TIMER_BITS-1:0] timer_dec;

	logic                  active_n;
	proto_t                proto_n;
	logic [DATA_BITS-1:0]  data_n;
	logic [ADDR_BITS-1:0]  addr_n;
	logic [CNT_W-1:0]      bits_left_n;
	logic [CNT_W-1:0]      bit_total_n;
	phase_t                phase_n;
	logic [TIMER_BITS-1:0] timer_n;
	logic                  level_n;
	logic                  skip_n;
	logic                  use_addr;

	seg_in_t  seg_in;
	seg_out_t seg_out;
	result_t  res_n;

	assign req_stall = skid_v_q;
	assign accept    = req_valid && !req_stall;
	assign take      = out_v_q && !res_stall;

	assign is_tick    = !operation;
	assign start_take = operation && !active_q;

	// Bit counts above the data width are clipped to it.
	assign n_sat  = (bit_count > DATA_BITS_6) ? DATA_BITS_6 : bit_count;
	assign sh_amt = SH_W'(DATA_BITS_6 - n_sat);

	assign timer_dec = timer_q - TIMER_BITS'(timer_q != '0);

	always_comb begin
		proto_n     = proto_q;
		data_n      = data_q;
		addr_n      = addr_q;
		bits_left_n = bits_left_q;
		bit_total_n = bit_total_q;
		skip_n      = skip_q;
		if (start_take) begin
			proto_n = proto_t'(protocol);
			skip_n  = (proto_t'(protocol) == PR_JVC) && repeat_req;
			addr_n  = address;
			if (proto_t'(protocol) == PR_PANA) begin
				data_n      = payload;
				bits_left_n = PANA_CNT;
				bit_total_n = PANA_CNT;
			end else begin
				// For Sony, RC5, RC6 and JVC, short words are moved to the top so their first bit leads.
				if ((proto_t'(protocol) == PR_SONY || proto_t'(protocol) == PR_RC5 ||
					proto_t'(protocol) == PR_RC6 || proto_t'(protocol) == PR_JVC) &&
					n_sat != 6'd0) begin
					data_n = payload << sh_amt;
				end
				bits_left_n = CNT_W'(n_sat);
				bit_total_n = CNT_W'(n_sat);
			end
		end
	end

	// Panasonic sends its address bits while more than a data word remains.
	assign use_addr = (proto_n == PR_PANA) && (bits_left_n > DATA_CNT);

	assign seg_in = '{
		proto:     proto_n,
		phase:     start_take ? PH_LEAD_MARK : phase_q,
		skip_hdr:  skip_n,
		bits_zero: (bits_left_n == '0),
		cur_bit:   use_addr ? addr_n[ADDR_BITS-1] : data_n[DATA_BITS-1],
		rc6_wide:  ((bit_total_n - bits_left_n) == RC6_WIDE_IX)
	};

	irpe_seg u_seg (
		.seg_in  (seg_in),
		.seg_out (seg_out)
	);

	// A segment is loaded at a frame start or when a tick runs the timer out.
	assign run = start_take || (is_tick && active_q && timer_dec == '0);

	always_comb begin
		active_n = active_q;
		phase_n  = phase_q;
		timer_n  = timer_q;
		level_n  = level_q;
		if (is_tick && active_q) begin
			timer_n = timer_dec;
		end
		if (run) begin
			if (seg_out.found) begin
				active_n = 1'b1;
				phase_n  = seg_out.next;
				timer_n  = TIMER_BITS'(seg_out.dur);
				level_n  = seg_out.level;
			end else begin
				active_n = 1'b0;
				phase_n  = PH_IDLE;
				timer_n  = '0;
				level_n  = 1'b0;
			end
		end
	end

	always_comb begin
		res_n.mark = is_tick && active_q && level_q;
		res_n.busy = operation ? active_n : active_q;
		res_n.acc  = start_take;
		res_n.khz  = res_n.busy ? carrier_of(proto_n) : 6'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			proto_q     <= PR_SONY;
			data_q      <= '0;
			addr_q      <= '0;
			bits_left_q <= '0;
			bit_total_q <= '0;
			phase_q     <= PH_IDLE;
			timer_q     <= '0;
			level_q     <= 1'b0;
			skip_q      <= 1'b0;
		end else if (accept) begin
			active_q    <= active_n;
			proto_q     <= proto_n;
			bit_total_q <= bit_total_n;
			phase_q     <= phase_n;
			timer_q     <= timer_n;
			level_q     <= level_n;
			skip_q      <= skip_n;
			if (run && seg_out.found && seg_out.shift) begin
				if (use_addr) begin
					addr_q <= addr_n << 1;
					data_q <= data_n;
				end else begin
					addr_q <= addr_n;
					data_q <= data_n << 1;
				end
				bits_left_q <= (bits_left_n != '0) ? bits_left_n - CNT_W'(1) : bits_left_n;
			end else begin
				addr_q      <= addr_n;
				data_q      <= data_n;
				bits_left_q <= bits_left_n;
			end
		end
	end

	// Output buffer. While the skid entry is full no request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (accept) begin
			if (!out_v_q || take) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (take) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!out_v_q || take) begin
				out_q <= res_n;
			end else begin
				skid_q <= res_n;
			end
		end else if (take && skid_v_q) begin
			out_q <= skid_q;
		end
	end

	assign res_valid      = out_v_q;
	assign ir_mark        = out_q.mark;
	assign busy_res       = out_q.busy;
	assign start_accepted = out_q.acc;
	assign carrier_khz    = out_q.khz;

`include "ir_remote_pulse_encoder_assert.svh"

	`IRPE_ASSERT_NOW(a_skid_behind_main, skid_v_q, out_v_q, "skid entry full while main entry empty")
	`IRPE_ASSERT_NEXT(a_start_runs, accept && start_take, active_q, "accepted start did not begin a frame")
	`IRPE_ASSERT_NOW(a_idle_quiet, !active_q, phase_q == PH_IDLE && !level_q, "idle frame state not at rest")
	`IRPE_ASSERT_NOW(a_idle_no_carrier, res_valid && !busy_res, carrier_khz == 6'd0 && !ir_mark, "idle result carries a carrier or a mark")

endmodule

`default_nettype wire
